>>> hw/rtl/apec_pkg.sv
// ----------------------------------------------------------------------------
// apec_pkg
// Shared widths, pattern constants, register indexes and interface structs
// for the alternating pattern error checker.
// ----------------------------------------------------------------------------
package apec_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CntW     = 20;
  localparam int unsigned ErrW     = 23;
  localparam int unsigned PctW     = 7;
  localparam int unsigned WinW     = 8;
  localparam int unsigned PcW      = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // serial divider: numerator is errors*100, denominator is words*8
  localparam int unsigned NumW     = 30;
  localparam int unsigned DenW     = 23;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned StepW    = $clog2(DivSteps + 1);
  localparam int unsigned PctScale = 100;

  localparam logic [ByteW-1:0] PatFives = 8'h55;
  localparam logic [ByteW-1:0] PatAs    = 8'hAA;

  localparam logic [CfgIdxW-1:0] CfgWindow    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLimit     = 2'd2;

  localparam logic [WinW-1:0]     WindowReset    = 8'd25;
  localparam logic [PctW-1:0]     ThresholdReset = 7'd40;
  localparam logic [CntW-1:0]     LimitReset     = 20'd524288;

  // classified byte: mismatch bit counts against both pattern phases
  typedef struct packed {
    logic           last;
    logic [PcW-1:0] pc_fives;
    logic [PcW-1:0] pc_as;
  } item_t;

  typedef struct packed {
    logic [WinW-1:0] window_words;
    logic [PctW-1:0] threshold_percent;
    logic [CntW-1:0] word_limit;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NumW-1:0] quot;
    logic [DenW-1:0] rem;
  } div_rsp_t;

  function automatic logic [PcW-1:0] popcount8(input logic [ByteW-1:0] v);
    logic [PcW-1:0] n;
    n = '0;
    for (int i = 0; i < ByteW; i++) begin
      n = n + PcW'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/apec_front.sv
// ----------------------------------------------------------------------------
// apec_front
// Input side: takes bytes off the input channel and classifies them into
// mismatch bit counts for both pattern phases before queueing.
// ----------------------------------------------------------------------------
module apec_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [apec_pkg::ByteW-1:0] in_data_byte,
  input  logic                      in_last_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output apec_pkg::item_t           q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.last     = in_last_byte;
    q_item.pc_fives = apec_pkg::popcount8(in_data_byte ^ apec_pkg::PatFives);
    q_item.pc_as    = apec_pkg::popcount8(in_data_byte ^ apec_pkg::PatAs);
  end

endmodule

>>> hw/rtl/apec_fifo.sv
// ----------------------------------------------------------------------------
// apec_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module apec_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  apec_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output apec_pkg::item_t pop_item
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  apec_pkg::item_t      mem_r [DEPTH];
  logic [PtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full     = (count_r == CntBits'(DEPTH));
  assign valid    = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/apec_div.sv
// ----------------------------------------------------------------------------
// apec_div
// Restoring divider, one quotient bit per cycle, shared by the percentage
// and the window remainder.
// ----------------------------------------------------------------------------
module apec_div (
  input  logic                clk,
  input  logic                rst_n,
  input  apec_pkg::div_req_t  req,
  output apec_pkg::div_rsp_t  rsp
);

  logic [apec_pkg::StepW-1:0] step_r;
  logic [apec_pkg::DenW-1:0]  rem_r;
  logic [apec_pkg::NumW-1:0]  quo_r;
  logic [apec_pkg::DenW-1:0]  den_r;
  logic                       done_r;
  logic [apec_pkg::DenW:0]    trial;
  logic [apec_pkg::DenW:0]    diff;
  logic                       ge;

  assign trial = {rem_r, quo_r[apec_pkg::NumW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rsp.busy = (step_r != '0);
    rsp.done = done_r;
    rsp.quot = quo_r;
    rsp.rem  = rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      step_r <= apec_pkg::StepW'(apec_pkg::DivSteps);
      done_r <= 1'b0;
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
      done_r <= (step_r == apec_pkg::StepW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (step_r != '0) begin
      rem_r <= ge ? diff[apec_pkg::DenW-1:0] : trial[apec_pkg::DenW-1:0];
      quo_r <= {quo_r[apec_pkg::NumW-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/apec_back.sv
// ----------------------------------------------------------------------------
// apec_back
// Execution side: pattern phase, counters, window checks, word limit and
// the result register.
// ----------------------------------------------------------------------------
module apec_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  apec_pkg::cfg_t              cfg,
  input  logic                        win_wr,
  input  logic                        q_valid,
  input  apec_pkg::item_t             q_item,
  output logic                        q_pop,
  output apec_pkg::div_req_t          div_req,
  input  apec_pkg::div_rsp_t          div_rsp,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_locked,
  output logic                        out_done_res,
  output logic [apec_pkg::CntW-1:0]   out_count_fives,
  output logic [apec_pkg::CntW-1:0]   out_count_as,
  output logic [apec_pkg::ErrW-1:0]   out_flipped_bits,
  output logic [apec_pkg::CntW-1:0]   out_words_seen,
  output logic [apec_pkg::PctW-1:0]   out_error_percent,
  output logic                        out_percent_valid
);

  localparam logic [2:0] S_RUN   = 3'd0;
  localparam logic [2:0] S_DIVGO = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_SYNC  = 3'd4;

  localparam int unsigned CntW = apec_pkg::CntW;
  localparam int unsigned ErrW = apec_pkg::ErrW;
  localparam int unsigned PctW = apec_pkg::PctW;
  localparam int unsigned WinW = apec_pkg::WinW;
  localparam int unsigned NumW = apec_pkg::NumW;
  localparam int unsigned DenW = apec_pkg::DenW;

  logic [2:0]      state_r, state_nxt;
  logic            exp_fives_r, exp_fives_nxt;
  logic            searching_r, searching_nxt;
  logic            finished_r, finished_nxt;
  logic [CntW-1:0] words_r, words_nxt;
  logic [ErrW-1:0] errs_r, errs_nxt;
  logic [CntW-1:0] fives_r, fives_nxt;
  logic [CntW-1:0] as_r, as_nxt;
  logic [WinW-1:0] wmod_r, wmod_nxt;
  logic            resync_r, resync_nxt;
  logic [PctW-1:0] done_pct_r, done_pct_nxt;
  logic            last_r, last_nxt;
  logic            check_r, check_nxt;
  logic [PctW-1:0] pct_r, pct_nxt;
  logic            pv_r, pv_nxt;

  logic            ov_r, ov_nxt;
  logic            o_locked_r, o_locked_nxt;
  logic            o_done_r, o_done_nxt;
  logic [CntW-1:0] o_fives_r, o_fives_nxt;
  logic [CntW-1:0] o_as_r, o_as_nxt;
  logic [ErrW-1:0] o_errs_r, o_errs_nxt;
  logic [CntW-1:0] o_words_r, o_words_nxt;
  logic [PctW-1:0] o_pct_r, o_pct_nxt;
  logic            o_pv_r, o_pv_nxt;

  logic [WinW-1:0]          win_eff;
  logic                     out_free;
  logic [apec_pkg::PcW-1:0] exp_pc;
  logic                     match;
  logic [CntW-1:0]          words_inc;
  logic [WinW-1:0]          wmod_inc;
  logic                     hit;
  logic                     fin;
  logic                     over;
  logic                     pv_chk;

  assign win_eff   = (cfg.window_words == '0) ? WinW'(1) : cfg.window_words;
  assign out_free  = !ov_r || out_ready;
  assign exp_pc    = exp_fives_r ? q_item.pc_fives : q_item.pc_as;
  assign match     = (exp_pc == '0);
  assign words_inc = words_r + 1'b1;
  assign wmod_inc  = wmod_r + 1'b1;
  assign hit       = searching_r && (wmod_inc == win_eff);
  assign over      = (div_rsp.quot > NumW'(cfg.threshold_percent));

  always_comb begin
    state_nxt     = state_r;
    exp_fives_nxt = exp_fives_r;
    searching_nxt = searching_r;
    finished_nxt  = finished_r;
    words_nxt     = words_r;
    errs_nxt      = errs_r;
    fives_nxt     = fives_r;
    as_nxt        = as_r;
    wmod_nxt      = wmod_r;
    resync_nxt    = resync_r;
    done_pct_nxt  = done_pct_r;
    last_nxt      = last_r;
    check_nxt     = check_r;
    pct_nxt       = pct_r;
    pv_nxt        = pv_r;
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    fin           = 1'b0;
    pv_chk        = 1'b0;

    ov_nxt       = out_ready ? 1'b0 : ov_r;
    o_locked_nxt = o_locked_r;
    o_done_nxt   = o_done_r;
    o_fives_nxt  = o_fives_r;
    o_as_nxt     = o_as_r;
    o_errs_nxt   = o_errs_r;
    o_words_nxt  = o_words_r;
    o_pct_nxt    = o_pct_r;
    o_pv_nxt     = o_pv_r;

    unique case (state_r)
      S_RUN: begin
        if (resync_r) begin
          // window length changed: rebuild words mod window
          div_req.start = 1'b1;
          div_req.num   = NumW'(words_r);
          div_req.den   = DenW'(win_eff);
          resync_nxt    = 1'b0;
          state_nxt     = S_SYNC;
        end else if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (finished_r) begin
            ov_nxt       = 1'b1;
            o_locked_nxt = !searching_r;
            o_done_nxt   = 1'b1;
            o_fives_nxt  = fives_r;
            o_as_nxt     = as_r;
            o_errs_nxt   = errs_r;
            o_words_nxt  = words_r;
            o_pct_nxt    = done_pct_r;
            o_pv_nxt     = 1'b1;
          end else begin
            words_nxt     = words_inc;
            exp_fives_nxt = !exp_fives_r;
            last_nxt      = q_item.last;
            wmod_nxt      = hit ? '0 : wmod_inc;
            if (match && exp_fives_r) begin
              fives_nxt = fives_r + 1'b1;
            end else if (match) begin
              as_nxt = as_r + 1'b1;
            end else begin
              errs_nxt = errs_r + ErrW'(exp_pc);
            end
            if (hit) begin
              check_nxt = 1'b1;
              state_nxt = S_DIVGO;
            end else begin
              fin          = (words_inc >= cfg.word_limit);
              finished_nxt = fin;
              if (q_item.last || fin) begin
                check_nxt = 1'b0;
                state_nxt = S_DIVGO;
              end else begin
                ov_nxt       = 1'b1;
                o_locked_nxt = !searching_r;
                o_done_nxt   = 1'b0;
                o_fives_nxt  = fives_nxt;
                o_as_nxt     = as_nxt;
                o_errs_nxt   = errs_nxt;
                o_words_nxt  = words_nxt;
                o_pct_nxt    = '0;
                o_pv_nxt     = 1'b0;
              end
            end
          end
        end
      end
      S_DIVGO: begin
        div_req.start = 1'b1;
        div_req.num   = NumW'(errs_r) * NumW'(apec_pkg::PctScale);
        div_req.den   = {words_r, 3'b000};
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (check_r) begin
            if (over) begin
              words_nxt = '0;
              errs_nxt  = '0;
              fives_nxt = '0;
              as_nxt    = '0;
              fin       = (cfg.word_limit == '0);
            end else begin
              searching_nxt = 1'b0;
              fin           = (words_r >= cfg.word_limit);
            end
            pv_chk       = last_r || fin;
            finished_nxt = fin;
            pv_nxt       = pv_chk;
            pct_nxt      = (pv_chk && !over) ? PctW'(div_rsp.quot) : '0;
            if (fin) begin
              done_pct_nxt = (!over) ? PctW'(div_rsp.quot) : '0;
            end
          end else begin
            pv_nxt  = 1'b1;
            pct_nxt = PctW'(div_rsp.quot);
            if (finished_r) begin
              done_pct_nxt = PctW'(div_rsp.quot);
            end
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_locked_nxt = !searching_r;
          o_done_nxt   = finished_r;
          o_fives_nxt  = fives_r;
          o_as_nxt     = as_r;
          o_errs_nxt   = errs_r;
          o_words_nxt  = words_r;
          o_pct_nxt    = pct_r;
          o_pv_nxt     = pv_r;
          state_nxt    = S_RUN;
        end
      end
      S_SYNC: begin
        if (div_rsp.done) begin
          wmod_nxt  = div_rsp.rem[WinW-1:0];
          state_nxt = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase

    // a new window length always wins over a pass just started
    if (win_wr) begin
      resync_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      exp_fives_r <= 1'b1;
      searching_r <= 1'b1;
      finished_r  <= 1'b0;
      words_r     <= '0;
      errs_r      <= '0;
      fives_r     <= '0;
      as_r        <= '0;
      wmod_r      <= '0;
      resync_r    <= 1'b0;
      done_pct_r  <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_fives_r <= exp_fives_nxt;
      searching_r <= searching_nxt;
      finished_r  <= finished_nxt;
      words_r     <= words_nxt;
      errs_r      <= errs_nxt;
      fives_r     <= fives_nxt;
      as_r        <= as_nxt;
      wmod_r      <= wmod_nxt;
      resync_r    <= resync_nxt;
      done_pct_r  <= done_pct_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    check_r    <= check_nxt;
    pct_r      <= pct_nxt;
    pv_r       <= pv_nxt;
    o_locked_r <= o_locked_nxt;
    o_done_r   <= o_done_nxt;
    o_fives_r  <= o_fives_nxt;
    o_as_r     <= o_as_nxt;
    o_errs_r   <= o_errs_nxt;
    o_words_r  <= o_words_nxt;
    o_pct_r    <= o_pct_nxt;
    o_pv_r     <= o_pv_nxt;
  end

  assign out_valid         = ov_r;
  assign out_locked        = o_locked_r;
  assign out_done_res      = o_done_r;
  assign out_count_fives   = o_fives_r;
  assign out_count_as      = o_as_r;
  assign out_flipped_bits  = o_errs_r;
  assign out_words_seen    = o_words_r;
  assign out_error_percent = o_pct_r;
  assign out_percent_valid = o_pv_r;

endmodule

>>> hw/rtl/alternating_pattern_error_checker.sv
// ----------------------------------------------------------------------------
// alternating_pattern_error_checker
// Checks a byte stream against the alternating 0x55 / 0xAA pattern, counts
// matches and flipped bits, and reports the error percentage.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  --------------------------------
//  in_      input      in_valid / in_ready   data_byte, last_byte
//  out_     output     out_valid / out_ready locked, done_res, counters,
//                                            error_percent, percent_valid
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  divider use: a plain byte does not use the divider; a byte that lands on a
//  window boundary while searching, or that carries the percentage, waits
//  for the 30-step serial divider
//  a write to window_words starts a remainder pass on the same
//  divider before the next byte is taken
//  reset: synchronous, active low; counters clear, expected pattern is 0x55
//  stalls: a 2-deep queue parts the input from the execution side, and the
//  result register lets a finished result wait while new bytes transfer in
//
module alternating_pattern_error_checker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [apec_pkg::ByteW-1:0]      in_data_byte,
  input  logic                            in_last_byte,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_locked,
  output logic                            out_done_res,
  output logic [apec_pkg::CntW-1:0]       out_count_fives,
  output logic [apec_pkg::CntW-1:0]       out_count_as,
  output logic [apec_pkg::ErrW-1:0]       out_flipped_bits,
  output logic [apec_pkg::CntW-1:0]       out_words_seen,
  output logic [apec_pkg::PctW-1:0]       out_error_percent,
  output logic                            out_percent_valid,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apec_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [apec_pkg::CfgDataW-1:0]   cfg_data
);

  // configuration registers
  logic [apec_pkg::WinW-1:0] window_words_r, window_words_nxt;
  logic [apec_pkg::PctW-1:0] threshold_r, threshold_nxt;
  logic [apec_pkg::CntW-1:0] word_limit_r, word_limit_nxt;
  logic                      cfg_xfer;
  logic                      win_wr;
  apec_pkg::cfg_t            cfg;

  // front to back queue
  logic                      q_full;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_valid;
  apec_pkg::item_t           push_item;
  apec_pkg::item_t           pop_item;

  // shared divider
  apec_pkg::div_req_t        div_req;
  apec_pkg::div_rsp_t        div_rsp;

  // config writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign win_wr    = cfg_xfer && (cfg_index == apec_pkg::CfgWindow);

  always_comb begin
    window_words_nxt = window_words_r;
    threshold_nxt    = threshold_r;
    word_limit_nxt   = word_limit_r;
    if (cfg_xfer) begin
      unique case (cfg_index)
        apec_pkg::CfgWindow: begin
          window_words_nxt = cfg_data[apec_pkg::WinW-1:0];
        end
        apec_pkg::CfgThreshold: begin
          threshold_nxt = cfg_data[apec_pkg::PctW-1:0];
        end
        apec_pkg::CfgLimit: begin
          word_limit_nxt = cfg_data[apec_pkg::CntW-1:0];
        end
        default: begin
          // index past the register list: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_words_r <= apec_pkg::WindowReset;
      threshold_r    <= apec_pkg::ThresholdReset;
      word_limit_r   <= apec_pkg::LimitReset;
    end else begin
      window_words_r <= window_words_nxt;
      threshold_r    <= threshold_nxt;
      word_limit_r   <= word_limit_nxt;
    end
  end

  always_comb begin
    cfg.window_words      = window_words_r;
    cfg.threshold_percent = threshold_r;
    cfg.word_limit        = word_limit_r;
  end

  // front: accept and classify each byte
  apec_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // decoupling queue
  apec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  // back: counters, window checks and results
  apec_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .win_wr            (win_wr),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_locked        (out_locked),
    .out_done_res      (out_done_res),
    .out_count_fives   (out_count_fives),
    .out_count_as      (out_count_as),
    .out_flipped_bits  (out_flipped_bits),
    .out_words_seen    (out_words_seen),
    .out_error_percent (out_error_percent),
    .out_percent_valid (out_percent_valid)
  );

  // percentage and window remainder divider
  apec_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // no percentage without the valid flag
  a_pct_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_percent_valid |-> out_error_percent == '0)
    else $error("error_percent set without percent_valid");

  // a done result always carries the percentage
  a_done_pv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_percent_valid)
    else $error("done result without percent_valid");

  // matches never exceed counted words
  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_count_fives} + {1'b0, out_count_as})
                  <= {1'b0, out_words_seen})
    else $error("match counters exceed words_seen");

  // at most eight flipped bits per counted word
  a_flip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_flipped_bits <= {out_words_seen, 3'b000})
    else $error("flipped_bits exceeds eight per word");

  // the divider is never restarted while it runs
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy || div_rsp.done)
    else $error("divider started while busy");

endmodule

>>> sim/tb_alternating_pattern_error_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alternating_pattern_error_checker
// Streams bytes into the alternating 0x55 / 0xAA checker while the search
// is active, after it locks and after the word limit stops it. An in-bench
// tally of the counters, lock and done flags predicts each result that the
// directed plan does not type in, and the result channel is compared field
// by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_alternating_pattern_error_checker;

  localparam int unsigned ByteW    = apec_pkg::ByteW;
  localparam int unsigned CntW     = apec_pkg::CntW;
  localparam int unsigned ErrW     = apec_pkg::ErrW;
  localparam int unsigned PctW     = apec_pkg::PctW;
  localparam int unsigned WinW     = apec_pkg::WinW;
  localparam int unsigned CfgIdxW  = apec_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = apec_pkg::CfgDataW;

  localparam int QuietLimit = 2000;  // cycles with no transfer on any channel
  localparam int DrainSlack = 40;    // covers a window remainder pass still running
  localparam int TailSlack  = 64;
  localparam int PlanRows   = 18;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;  // unmapped register slot

  // one result as it leaves the block
  typedef struct packed {
    logic            locked;
    logic            done_res;
    logic [CntW-1:0] count_fives;
    logic [CntW-1:0] count_as;
    logic [ErrW-1:0] flipped_bits;
    logic [CntW-1:0] words_seen;
    logic [PctW-1:0] error_percent;
    logic            percent_valid;
  } tally_t;

  // directed step: optional register write, then one byte
  typedef struct {
    bit                  retune;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [ByteW-1:0]    data;
    logic                last;
    bit                  known;
    tally_t              seen;
  } plan_row_t;

  typedef enum {ShapeGood, ShapeSlip, ShapeFlip, ShapeNoise, ShapeHeavy} shape_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [ByteW-1:0]    in_data_byte  = '0;
  logic                in_last_byte  = 1'b0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                out_locked;
  logic                out_done_res;
  logic [CntW-1:0]     out_count_fives;
  logic [CntW-1:0]     out_count_as;
  logic [ErrW-1:0]     out_flipped_bits;
  logic [CntW-1:0]     out_words_seen;
  logic [PctW-1:0]     out_error_percent;
  logic                out_percent_valid;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index     = apec_pkg::CfgWindow;
  logic [CfgDataW-1:0] cfg_data      = '0;

  alternating_pattern_error_checker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_locked        (out_locked),
    .out_done_res      (out_done_res),
    .out_count_fives   (out_count_fives),
    .out_count_as      (out_count_as),
    .out_flipped_bits  (out_flipped_bits),
    .out_words_seen    (out_words_seen),
    .out_error_percent (out_error_percent),
    .out_percent_valid (out_percent_valid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // predicted checker state, starting from its reset values
  logic [WinW-1:0] win_cfg    = apec_pkg::WindowReset;
  logic [PctW-1:0] thr_cfg    = apec_pkg::ThresholdReset;
  logic [CntW-1:0] lim_cfg    = apec_pkg::LimitReset;
  logic            fives_turn = 1'b1;
  logic            hunting    = 1'b1;
  logic            done_q     = 1'b0;
  logic [CntW-1:0] words_q    = '0;
  logic [ErrW-1:0] flips_q    = '0;
  logic [CntW-1:0] fives_q    = '0;
  logic [CntW-1:0] aas_q      = '0;

  tally_t    tallies_due[$];  // predicted results, oldest first
  int        mismatches   = 0;
  int        burst_left   = 0;
  int        sent         = 0;
  int        slip_left    = 0;
  int        stall_left   = 0;
  int        quiet_cycles = 0;
  int        rx_cycle     = 0;
  plan_row_t plan [PlanRows];

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // floor(flips*100 / (words*8)), zero with no words
  function automatic int unsigned error_share(input logic [ErrW-1:0] flips,
                                              input logic [CntW-1:0] words);
    longint unsigned num;
    longint unsigned den;
    if (words == '0) return 0;
    num = flips;
    num = num * apec_pkg::PctScale;
    den = words;
    den = den * 8;
    return 32'(num / den);
  endfunction

  // counts one byte against the expected phase and returns the result it causes
  function automatic tally_t tally_byte(input logic [ByteW-1:0] data, input logic last);
    logic [ByteW-1:0] want;
    int unsigned      span;
    tally_t           r;
    if (!done_q) begin
      span = (win_cfg == '0) ? 1 : int'(win_cfg);  // zero window behaves as one
      want = fives_turn ? apec_pkg::PatFives : apec_pkg::PatAs;
      words_q = words_q + 1'b1;
      if (data == apec_pkg::PatAs && !fives_turn) begin
        aas_q = aas_q + 1'b1;
      end else if (data == apec_pkg::PatFives && fives_turn) begin
        fives_q = fives_q + 1'b1;
      end else begin
        flips_q = flips_q + ErrW'($countones(data ^ want));
      end
      fives_turn = !fives_turn;
      // window check: restart the search or lock for good
      if (hunting && (words_q % span) == 0) begin
        if (error_share(flips_q, words_q) > thr_cfg) begin
          words_q = '0;
          flips_q = '0;
          fives_q = '0;
          aas_q   = '0;
        end else begin
          hunting = 1'b0;
        end
      end
      if (words_q >= lim_cfg) done_q = 1'b1;
    end
    r.locked        = !hunting;
    r.done_res      = done_q;
    r.count_fives   = fives_q;
    r.count_as      = aas_q;
    r.flipped_bits  = flips_q;
    r.words_seen    = words_q;
    r.percent_valid = last | done_q;
    r.error_percent = r.percent_valid ? PctW'(error_share(flips_q, words_q)) : '0;
    return r;
  endfunction

  // next byte of a given shape relative to the phase the checker expects now
  function automatic logic [ByteW-1:0] shape_byte(input shape_t kind);
    logic [ByteW-1:0] want;
    logic [ByteW-1:0] mask;
    want = fives_turn ? apec_pkg::PatFives : apec_pkg::PatAs;
    mask = 8'($urandom);
    case (kind)
      ShapeGood: mask = '0;
      ShapeSlip: mask = '1;  // opposite phase, as from a shifted stream
      ShapeFlip: mask = 8'(1) << $urandom_range(0, 7);
      ShapeHeavy: begin
        if ($countones(mask) < 4) mask = ~mask;  // at least half the bits wrong
      end
      default: ;  // noise keeps the random mask
    endcase
    return want ^ mask;
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan rows
  // ---------------------------------------------------------------------------

  function automatic plan_row_t free_row(input logic [ByteW-1:0] d, input logic l);
    plan_row_t r;
    r.retune  = 1'b0;
    r.reg_idx = apec_pkg::CfgWindow;
    r.reg_val = '0;
    r.data    = d;
    r.last    = l;
    r.known   = 1'b0;
    r.seen    = '0;
    return r;
  endfunction

  // typed result while still searching and not done
  function automatic plan_row_t known_row(input logic [ByteW-1:0] d, input logic l,
                                          input int f5, input int fa, input int fl,
                                          input int w, input int p, input logic pv);
    plan_row_t r;
    r = free_row(d, l);
    r.known              = 1'b1;
    r.seen.count_fives   = CntW'(f5);
    r.seen.count_as      = CntW'(fa);
    r.seen.flipped_bits  = ErrW'(fl);
    r.seen.words_seen    = CntW'(w);
    r.seen.error_percent = PctW'(p);
    r.seen.percent_valid = pv;
    return r;
  endfunction

  function automatic plan_row_t retune_row(input logic [CfgIdxW-1:0] idx,
                                           input logic [CfgDataW-1:0] val,
                                           input logic [ByteW-1:0] d, input logic l);
    plan_row_t r;
    r = free_row(d, l);
    r.retune  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one byte transfer, with a random gap at the start of each burst
  task automatic send_byte(input logic [ByteW-1:0] data, input logic last,
                           input bit known, input tally_t seen);
    int unsigned gap;
    tally_t      due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || (sent % 400) < 100) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due = tally_byte(data, last);
    tallies_due.push_back(known ? seen : due);
    burst_left--;
    sent++;
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain_and_wait();
    in_valid <= 1'b0;
    while (tallies_due.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    drain_and_wait();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      apec_pkg::CfgWindow:    win_cfg = val[WinW-1:0];
      apec_pkg::CfgThreshold: thr_cfg = val[PctW-1:0];
      apec_pkg::CfgLimit:     lim_cfg = val[CntW-1:0];
      default: ;  // spare slot holds nothing
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // clock, receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: free-flowing while bit 9 of rx_cycle is set and no hold is pending,
  // otherwise sparse stalls plus an occasional long hold
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_cycle[9]) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 47) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(8, 24);
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // every result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    tally_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tallies_due.size() == 0) begin
        $error("result transfer with no prediction pending");
        mismatches++;
      end else begin
        want = tallies_due.pop_front();
        check_field("locked", want.locked, out_locked);
        check_field("done_res", want.done_res, out_done_res);
        check_field("count_fives", want.count_fives, out_count_fives);
        check_field("count_as", want.count_as, out_count_as);
        check_field("flipped_bits", want.flipped_bits, out_flipped_bits);
        check_field("words_seen", want.words_seen, out_words_seen);
        check_field("error_percent", want.error_percent, out_error_percent);
        check_field("percent_valid", want.percent_valid, out_percent_valid);
      end
    end
  end

  // a hang anywhere shows up as a long stretch with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int          roll;
    int          span;
    shape_t      kind;
    logic [WinW-1:0] pick_win;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset defaults first, then a one-word window at zero threshold
    // so every wrong byte clears, then a two-word window that keeps restarting
    plan = '{
      known_row(8'h55, 1'b0, 1, 0, 0, 1, 0, 1'b0),   // first match on 0x55
      known_row(8'hAA, 1'b1, 1, 1, 0, 2, 0, 1'b1),   // match on 0xAA, percent shown
      known_row(8'h00, 1'b0, 1, 1, 4, 3, 0, 1'b0),   // all zeros vs 0x55
      known_row(8'hFF, 1'b1, 1, 1, 8, 4, 25, 1'b1),  // all ones vs 0xAA
      known_row(8'hAA, 1'b0, 1, 1, 16, 5, 0, 1'b0),  // wrong phase, every bit off
      known_row(8'h55, 1'b1, 1, 1, 24, 6, 50, 1'b1),
      retune_row(apec_pkg::CfgThreshold, 20'd0, 8'h80, 1'b0),
      retune_row(apec_pkg::CfgWindow, 20'd0, 8'hAB, 1'b1),  // zero window, clear on this byte
      known_row(8'h01, 1'b1, 0, 0, 0, 0, 0, 1'b1),   // cleared: percent reads zero
      known_row(8'h7F, 1'b0, 0, 0, 0, 0, 0, 1'b0),
      retune_row(apec_pkg::CfgWindow, 20'd2, 8'h55, 1'b0),
      retune_row(apec_pkg::CfgThreshold, 20'd30, 8'h55, 1'b1),
      free_row(8'h55, 1'b0),
      free_row(8'h40, 1'b1),
      free_row(8'hFF, 1'b0),
      free_row(8'h7F, 1'b0),
      retune_row(apec_pkg::CfgLimit, 20'hFFFFF, 8'h00, 1'b1),  // largest word limit
      free_row(8'hFF, 1'b0)
    };
    foreach (plan[i]) begin
      if (plan[i].retune) write_reg(plan[i].reg_idx, plan[i].reg_val);
      send_byte(plan[i].data, plan[i].last, plan[i].known, plan[i].seen);
    end

    // search phase: mostly badly wrong bytes so windows keep failing;
    // exact matches only where the window is wide enough to absorb them
    for (int sp = 0; sp < 8; sp++) begin
      span     = 80;
      pick_win = WinW'($urandom_range(1, 40));
      if (sp == 0) begin
        pick_win = 8'd255;
        span     = 280;
      end else if (sp == 3) begin
        pick_win = '0;
        span     = 40;
      end
      write_reg(apec_pkg::CfgWindow, CfgDataW'(pick_win));
      write_reg(apec_pkg::CfgThreshold, CfgDataW'($urandom_range(0, 45)));
      repeat (span) begin
        roll = $urandom_range(0, 99);
        if (win_cfg < 8 || roll >= 20) kind = ShapeHeavy;
        else if (roll < 10) kind = ShapeGood;
        else kind = ShapeNoise;
        send_byte(shape_byte(kind), $urandom_range(0, 11) == 0, 1'b0, '0);
      end
    end

    // a threshold above 100 can never be exceeded, so the next window locks
    write_reg(apec_pkg::CfgThreshold, 20'd127);
    write_reg(apec_pkg::CfgWindow, CfgDataW'($urandom_range(1, 20)));

    // locked: clean pattern with injected bit errors, noise and phase slips
    for (int k = 0; k < 850; k++) begin
      if (k == 250) write_reg(apec_pkg::CfgLimit, 20'hFFFFF);
      if (k == 500) begin
        write_reg(apec_pkg::CfgWindow, 20'd255);
        write_reg(apec_pkg::CfgThreshold, 20'd100);
      end
      if (k == 650) write_reg(CfgSpare, CfgDataW'($urandom));
      roll = $urandom_range(0, 99);
      if (slip_left == 0 && roll < 2) slip_left = $urandom_range(3, 20);
      if (slip_left != 0) begin
        kind = ShapeSlip;
        slip_left--;
      end else if (roll < 72) begin
        kind = ShapeGood;
      end else if (roll < 82) begin
        kind = ShapeFlip;
      end else if (roll < 92) begin
        kind = ShapeNoise;
      end else begin
        kind = ShapeHeavy;
      end
      send_byte(shape_byte(kind), $urandom_range(0, 15) == 0, 1'b0, '0);
    end

    // zero word limit: the next counted byte raises done, the rest are ignored
    write_reg(apec_pkg::CfgLimit, '0);
    repeat (120) begin
      kind = shape_t'($urandom_range(0, 4));
      send_byte(shape_byte(kind), $urandom_range(0, 1) == 1, 1'b0, '0);
    end

    drain_and_wait();
    repeat (TailSlack) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
